[design/ogom_pkg.sv]
// Shared types and codes of the occupancy grid offset merge block.
`default_nettype none
package ogom_pkg;

	// Item actions
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_MERGE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;
	// Spare code: touches nothing; its result shows no data, no write and in_bounds low
	localparam logic [1:0] ACT_NONE  = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] CFG_OFFSET_X  = 3'd0;
	localparam logic [2:0] CFG_OFFSET_Y  = 3'd1;
	localparam logic [2:0] CFG_GRID_W    = 3'd2;
	localparam logic [2:0] CFG_GRID_H    = 3'd3;
	localparam logic [2:0] CFG_OVERWRITE = 3'd4;

	// Cell value meaning "not yet observed"
	localparam logic signed [7:0] UNKNOWN_CELL = -8'sd1;

	// Request travelling down the pipeline behind its address
	typedef struct packed {
		logic [1:0]        action;
		logic signed [7:0] value;
		logic              in_bounds;
	} ogom_item_t;

endpackage
`default_nettype wire

[design/ogom_locate.sv]
// Offset, bounds check and row-major address of one request, over two stages.
`default_nettype none
module ogom_locate
	import ogom_pkg::*;
#(
	parameter int MAX_CELLS = 16384,
	parameter int MAX_SIDE  = 128,
	parameter int AW        = 14
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire logic              in_valid,
	input  wire logic [1:0]        action,
	input  wire logic [6:0]        cell_x,
	input  wire logic [6:0]        cell_y,
	input  wire logic signed [7:0] cell_value,
	input  wire logic signed [7:0] offset_x,
	input  wire logic signed [7:0] offset_y,
	input  wire logic [7:0]        grid_width,
	input  wire logic [7:0]        grid_height,
	output logic                   valid_s2,
	output ogom_item_t             item_s2,
	output logic [AW-1:0]          addr_s2
);

	localparam logic [10:0] SIDE_LIM  = 11'(MAX_SIDE);
	localparam logic [20:0] CELL_LIM  = 21'(MAX_CELLS);
	localparam int          FW        = (AW > 16) ? AW : 16;

	logic signed [8:0] sx, sy;
	logic [7:0]        eff_w, eff_h;
	logic              coord_ok;

	logic              valid_s1;
	logic [1:0]        action_s1;
	logic signed [7:0] value_s1;
	logic              coord_ok_s1;
	logic [7:0]        x_s1, y_s1, w_s1;

	logic [15:0]       addr_full;
	logic [FW-1:0]     addr_ext;
	logic              cells_ok;

	// Shift only merge requests; clear and read address the fused grid directly.
	always_comb begin
		sx = $signed({2'b00, cell_x});
		sy = $signed({2'b00, cell_y});
		if (action == ACT_MERGE) begin
			sx = $signed({2'b00, cell_x}) + $signed({offset_x[7], offset_x});
			sy = $signed({2'b00, cell_y}) + $signed({offset_y[7], offset_y});
		end
		eff_w = ({3'b000, grid_width} > SIDE_LIM) ? SIDE_LIM[7:0] : grid_width;
		eff_h = ({3'b000, grid_height} > SIDE_LIM) ? SIDE_LIM[7:0] : grid_height;
		coord_ok = !sx[8] && !sy[8] && (sx[7:0] < eff_w) && (sy[7:0] < eff_h);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			action_s1   <= action;
			value_s1    <= cell_value;
			coord_ok_s1 <= coord_ok;
			x_s1        <= sx[7:0];
			y_s1        <= sy[7:0];
			w_s1        <= eff_w;
		end
	end

	always_comb begin
		addr_full = 16'(y_s1 * w_s1) + {8'h00, x_s1};
		addr_ext  = FW'(addr_full);
		cells_ok  = {5'b00000, addr_full} < CELL_LIM;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s2.action    <= action_s1;
			item_s2.value     <= value_s1;
			item_s2.in_bounds <= coord_ok_s1 && cells_ok;
			addr_s2           <= addr_ext[AW-1:0];
		end
	end

endmodule
`default_nettype wire

[design/ogom_cell_ram.sv]
// Fused grid storage: one write and one registered read port, write-first.
`default_nettype none
module ogom_cell_ram #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic signed [7:0] wr_data,
	output logic signed [7:0]      rd_data
);

	logic signed [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Forward a write landing in the same cycle so the next request sees it.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

endmodule
`default_nettype wire

[design/occupancy_grid_offset_merge.sv]
// Top level of the occupancy grid offset merge block.
//
// Keeps a fused occupancy grid of signed 8-bit cells in one on-chip memory,
// row by row (address = row * grid_width + column). Each request clears a
// cell to unknown (-1), merges a value from another map at a configured
// whole-cell offset, or reads a cell, and gives one result. The block takes
// one request per cycle while the result side does not stall. Two stages
// work out the shift, the bounds and the row-major address, the memory read
// issued from the second stage returns in the third, where the write-back
// is decided and done, and the result register follows. A write forwarded
// into the read register lets back-to-back requests to the same cell see
// each other. Any stall on the result side freezes the whole pipeline.
// Grid cells are undefined after reset: clear each cell before it is read
// or merged with overwrite off.
// Configuration is written through cfg_valid/cfg_ready; the user must write
// it only while no request is in flight, as the block does not enforce this.
`default_nettype none
module occupancy_grid_offset_merge
	import ogom_pkg::*;
#(
	parameter int MAX_CELLS = 16384,
	parameter int MAX_SIDE  = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        action,
	input  wire logic [6:0]        cell_x,
	input  wire logic [6:0]        cell_y,
	input  wire logic signed [7:0] cell_value,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [7:0]      read_value,
	output logic                   in_bounds,
	output logic                   written,
	// configuration channel
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [7:0]        cfg_data
);

	localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

	// configuration registers
	logic signed [7:0] offset_x_q, offset_y_q;
	logic [7:0]        grid_width_q, grid_height_q;
	logic              overwrite_q;

	logic              adv;
	logic              valid_s2, valid_s3;
	ogom_item_t        item_s2, item_s3;
	logic [AW-1:0]     addr_s2, addr_s3;
	logic signed [7:0] cur_value;

	logic              ram_we;
	logic signed [7:0] ram_wd;
	logic signed [7:0] rd_next;

	logic              out_valid_q;
	logic signed [7:0] read_value_q;
	logic              in_bounds_q, written_q;

	// Advance every stage together whenever the result register can move on.
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q    <= 8'sd0;
			offset_y_q    <= 8'sd0;
			grid_width_q  <= 8'd128;
			grid_height_q <= 8'd128;
			overwrite_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OFFSET_X:  offset_x_q    <= $signed(cfg_data);
				CFG_OFFSET_Y:  offset_y_q    <= $signed(cfg_data);
				CFG_GRID_W:    grid_width_q  <= cfg_data;
				CFG_GRID_H:    grid_height_q <= cfg_data;
				CFG_OVERWRITE: overwrite_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stages one and two: shift, bounds and address.
	ogom_locate #(
		.MAX_CELLS (MAX_CELLS),
		.MAX_SIDE  (MAX_SIDE),
		.AW        (AW)
	) u_locate (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_valid    (in_valid),
		.action      (action),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.cell_value  (cell_value),
		.offset_x    (offset_x_q),
		.offset_y    (offset_y_q),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.valid_s2    (valid_s2),
		.item_s2     (item_s2),
		.addr_s2     (addr_s2)
	);

	// Stage three: cell value arrives from memory alongside its request.
	ogom_cell_ram #(
		.DEPTH (MAX_CELLS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.rd_en   (adv && valid_s2 && item_s2.in_bounds),
		.rd_addr (addr_s2),
		.wr_en   (ram_we),
		.wr_addr (addr_s3),
		.wr_data (ram_wd),
		.rd_data (cur_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s3 <= item_s2;
			addr_s3 <= addr_s2;
		end
	end

	// Decide the write-back and the result; drop anything outside the grid.
	always_comb begin
		ram_we  = 1'b0;
		ram_wd  = item_s3.value;
		rd_next = 8'sd0;
		if (valid_s3 && item_s3.in_bounds) begin
			case (item_s3.action)
				ACT_CLEAR: begin
					ram_we = adv;
					ram_wd = UNKNOWN_CELL;
				end
				ACT_MERGE: begin
					ram_we = adv && (item_s3.value != UNKNOWN_CELL) &&
					         (overwrite_q || (cur_value == UNKNOWN_CELL));
				end
				ACT_READ: begin
					rd_next = cur_value;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			read_value_q <= rd_next;
			in_bounds_q  <= item_s3.in_bounds && (item_s3.action != ACT_NONE);
			written_q    <= ram_we;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign in_bounds  = in_bounds_q;
	assign written    = written_q;

	// A memory write belongs to a live, in-grid request that is moving on.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (valid_s3 && item_s3.in_bounds && adv))
		else $error("grid write without a live in-grid request");

	// A result that reports a write must lie inside the grid.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && written_q) |-> in_bounds_q)
		else $error("write reported for a cell outside the grid");

	// Only reads return data, and reads never change the grid.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (read_value_q != 8'sd0)) |-> (in_bounds_q && !written_q))
		else $error("read data on a result that is not an in-grid read");

	// While the result waits, the pipeline behind it must hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> ($stable(valid_s3) && $stable(addr_s3)))
		else $error("stage three moved during a result stall");

endmodule
`default_nettype wire
